// ===== hdl/baro_pressure_temp_compensation_core_macros.svh =====
// Assertion helpers used by the compensation core RTL.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bptc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bptc assertion failed");

`endif

// ===== hdl/bptc_pkg.sv =====
`default_nettype none

package bptc_pkg;

    // Field widths
    localparam int RAW_W  = 24;
    localparam int CF_W   = 16;
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 3;
    localparam int STAGES = 9;

    // Datapath widths (bounded by the 24-bit raw values and 16-bit coefficients)
    localparam int DT_W     = RAW_W + 1;          // dT
    localparam int MUL_W    = DT_W + CF_W + 1;    // dT * coefficient
    localparam int DD_W     = 2 * DT_W;           // dT * dT
    localparam int TSH_W    = 18;                 // (dT * C6) >>> 23, i.e. TEMP - 2000
    localparam int TEMP_W   = 20;                 // TEMP before and after T2
    localparam int DIFF2_W  = 19;                 // TEMP + 1500
    localparam int T2_W     = 17;                 // T2
    localparam int OFF1_W   = 36;                 // first-order OFF
    localparam int SENS1_W  = 35;                 // first-order SENS
    localparam int SQ1_W    = 35;                 // (TEMP - 2000)^2
    localparam int SQ2_W    = 36;                 // (TEMP + 1500)^2
    localparam int FIVE_W   = SQ1_W + 2;
    localparam int SEVEN_W  = SQ2_W + 3;
    localparam int ELEVEN_W = SQ2_W + 4;
    localparam int OFF_W    = 41;                 // final OFF and SENS
    localparam int SLO_W    = 21;                 // low slice of SENS for the split product
    localparam int PRD_W    = 45;                 // partial products and D1*SENS >>> 21
    localparam int RES_W    = PRD_W + 1;          // before the final >>> 15

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    localparam int TEMP_REF_VAL = 2000;
    localparam int TEMP_LOW_VAL = 1500;
    localparam logic signed [TEMP_W-1:0]  TEMP_REF  = TEMP_W'(TEMP_REF_VAL);
    localparam logic signed [DIFF2_W-1:0] DIFF2_OFS = DIFF2_W'(TEMP_REF_VAL + TEMP_LOW_VAL);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_SENS_BASE   = 3'd0,
        CFG_OFFSET_BASE = 3'd1,
        CFG_SENS_TC     = 3'd2,
        CFG_OFFSET_TC   = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_COEFF  = 3'd5
    } t_cfg_idx;

    // Calibration coefficients as seen by the datapath
    typedef struct packed {
        logic [CF_W-1:0] sens_base;
        logic [CF_W-1:0] offset_base;
        logic [CF_W-1:0] sens_temp_coeff;
        logic [CF_W-1:0] offset_temp_coeff;
        logic [CF_W-1:0] reference_temperature;
        logic [CF_W-1:0] temp_coeff;
    } t_coeffs;

endpackage

`default_nettype wire

// ===== hdl/bptc_cfg_regs.sv =====
`default_nettype none

module bptc_cfg_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [bptc_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire  [bptc_pkg::CF_W-1:0]    i_cfg_data,
    output bptc_pkg::t_coeffs            o_coeffs
);

    bptc_pkg::t_coeffs r_coeffs;

    // Writes are always taken; unknown indexes drop the item
    assign o_cfg_ready = 1'b1;
    assign o_coeffs    = r_coeffs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_valid) begin
            case (bptc_pkg::t_cfg_idx'(i_cfg_index))
                bptc_pkg::CFG_SENS_BASE:   r_coeffs.sens_base             <= i_cfg_data;
                bptc_pkg::CFG_OFFSET_BASE: r_coeffs.offset_base           <= i_cfg_data;
                bptc_pkg::CFG_SENS_TC:     r_coeffs.sens_temp_coeff       <= i_cfg_data;
                bptc_pkg::CFG_OFFSET_TC:   r_coeffs.offset_temp_coeff     <= i_cfg_data;
                bptc_pkg::CFG_REF_TEMP:    r_coeffs.reference_temperature <= i_cfg_data;
                bptc_pkg::CFG_TEMP_COEFF:  r_coeffs.temp_coeff            <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/baro_pressure_temp_compensation_core.sv =====
// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+----------------------------------------
// s (raw)   | in  | i_s_tvalid / o_s_tready   | i_s_tdata: press_code, temp_code
// m (result)| out | o_m_tvalid / i_m_tready   | o_m_tdata: temperature_centi, press_centi
//           |     |                           | o_m_tuser: valid_res
// cfg       | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data (always ready)
//
// Nine-stage pipeline: one item per cycle while the output is not stalled. The
// stage count is set by the multiplier ranks (dT products, square terms, split
// D1*SENS product) each followed by a register.
// Each stage holds only while it is full and the stage after it cannot move, so
// bubbles close up under a stalled output; the input is taken until all stages fill.
// i_rst_n is synchronous, active low; it empties the pipeline and clears the
// coefficients to zero.
`default_nettype none

`include "baro_pressure_temp_compensation_core_macros.svh"

module baro_pressure_temp_compensation_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // raw item
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [2*bptc_pkg::RAW_W-1:0]      i_s_tdata,   // [23:0] press_code, [47:24] temp_code
    // result item
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [2*bptc_pkg::OUT_W-1:0]      o_m_tdata,   // [31:0] temperature_centi, [63:32] press_centi
    output logic                              o_m_tuser,   // [0] valid_res
    // configuration
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bptc_pkg::IDX_W-1:0]        i_cfg_index,
    input  wire  [bptc_pkg::CF_W-1:0]         i_cfg_data
);

    bptc_pkg::t_coeffs s_coeffs;

    bptc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coeffs    (s_coeffs)
    );

    // ------------------------------------------------------------------
    // Flow control: per-stage valid bits and load enables
    // ------------------------------------------------------------------
    logic [bptc_pkg::STAGES-1:0] r_vld;
    logic [bptc_pkg::STAGES-1:0] s_en;

    always_comb begin
        s_en[bptc_pkg::STAGES-1] = !r_vld[bptc_pkg::STAGES-1] || i_m_tready;
        for (int k = bptc_pkg::STAGES - 2; k >= 0; k--) begin
            s_en[k] = !r_vld[k] || s_en[k+1];
        end
    end

    assign o_s_tready = s_en[0];
    assign o_m_tvalid = r_vld[bptc_pkg::STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < bptc_pkg::STAGES; k++) begin
                if (s_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: range check and dT
    // ------------------------------------------------------------------
    logic [bptc_pkg::RAW_W-1:0]         s_d1, s_d2;
    logic                               n_ok;
    logic signed [bptc_pkg::DT_W-1:0]   n_dt;
    logic                               r_ok_1;
    logic [bptc_pkg::RAW_W-1:0]         r_d1_1;
    logic signed [bptc_pkg::DT_W-1:0]   r_dt_1;

    assign s_d1 = i_s_tdata[bptc_pkg::RAW_W-1:0];
    assign s_d2 = i_s_tdata[2*bptc_pkg::RAW_W-1:bptc_pkg::RAW_W];
    assign n_ok = (s_d1 != '0) && (s_d2 != '0) &&
                  (s_d1 != bptc_pkg::RAW_MAX) && (s_d2 != bptc_pkg::RAW_MAX);
    assign n_dt = $signed({1'b0, s_d2}) -
                  $signed({1'b0, s_coeffs.reference_temperature, 8'h00});

    // ------------------------------------------------------------------
    // Stage 2: dT products
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::MUL_W-1:0] n_pt, n_po, n_ps;
    logic signed [bptc_pkg::DD_W-1:0]  n_dd;
    logic signed [bptc_pkg::MUL_W-1:0] r_pt_2, r_po_2, r_ps_2;
    logic signed [bptc_pkg::DD_W-1:0]  r_dd_2;
    logic                              r_ok_2;
    logic [bptc_pkg::RAW_W-1:0]        r_d1_2;

    assign n_pt = bptc_pkg::MUL_W'(r_dt_1) *
                  bptc_pkg::MUL_W'($signed({1'b0, s_coeffs.temp_coeff}));
    assign n_po = bptc_pkg::MUL_W'(r_dt_1) *
                  bptc_pkg::MUL_W'($signed({1'b0, s_coeffs.offset_temp_coeff}));
    assign n_ps = bptc_pkg::MUL_W'(r_dt_1) *
                  bptc_pkg::MUL_W'($signed({1'b0, s_coeffs.sens_temp_coeff}));
    assign n_dd = bptc_pkg::DD_W'(r_dt_1) * bptc_pkg::DD_W'(r_dt_1);

    // ------------------------------------------------------------------
    // Stage 3: first-order TEMP, OFF, SENS; T2; low-temperature flags
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::TSH_W-1:0]   s3_tsh;      // TEMP - 2000
    logic signed [bptc_pkg::TEMP_W-1:0]  n_temp1;
    logic signed [bptc_pkg::DIFF2_W-1:0] n_diff2;     // TEMP + 1500
    logic signed [bptc_pkg::OFF1_W-1:0]  n_off1;
    logic signed [bptc_pkg::SENS1_W-1:0] n_sens1;
    logic signed [bptc_pkg::TSH_W-1:0]   r_tsh_3;
    logic signed [bptc_pkg::DIFF2_W-1:0] r_diff2_3;
    logic signed [bptc_pkg::TEMP_W-1:0]  r_temp1_3;
    logic [bptc_pkg::T2_W-1:0]           r_t2_3;
    logic signed [bptc_pkg::OFF1_W-1:0]  r_off1_3;
    logic signed [bptc_pkg::SENS1_W-1:0] r_sens1_3;
    logic                                r_lo1_3, r_lo2_3, r_ok_3;
    logic [bptc_pkg::RAW_W-1:0]          r_d1_3;

    assign s3_tsh  = r_pt_2[23 +: bptc_pkg::TSH_W];
    assign n_temp1 = bptc_pkg::TEMP_W'(s3_tsh) + bptc_pkg::TEMP_REF;
    assign n_diff2 = bptc_pkg::DIFF2_W'(s3_tsh) + bptc_pkg::DIFF2_OFS;
    assign n_off1  = bptc_pkg::OFF1_W'($signed({4'b0000, s_coeffs.offset_base, 16'h0000})
                     + (r_po_2 >>> 7));
    assign n_sens1 = bptc_pkg::SENS1_W'($signed({4'b0000, s_coeffs.sens_base, 15'h0000})
                     + (r_ps_2 >>> 8));

    // ------------------------------------------------------------------
    // Stage 4: squares of the temperature differences
    // ------------------------------------------------------------------
    logic signed [2*bptc_pkg::TSH_W-1:0]   s4_p1;
    logic signed [2*bptc_pkg::DIFF2_W-1:0] s4_p2;
    logic [bptc_pkg::SQ1_W-1:0]            r_sq1_4;
    logic [bptc_pkg::SQ2_W-1:0]            r_sq2_4;
    logic signed [bptc_pkg::TEMP_W-1:0]    r_temp1_4;
    logic [bptc_pkg::T2_W-1:0]             r_t2_4;
    logic signed [bptc_pkg::OFF1_W-1:0]    r_off1_4;
    logic signed [bptc_pkg::SENS1_W-1:0]   r_sens1_4;
    logic                                  r_lo1_4, r_lo2_4, r_ok_4;
    logic [bptc_pkg::RAW_W-1:0]            r_d1_4;

    assign s4_p1 = (2*bptc_pkg::TSH_W)'(r_tsh_3) * (2*bptc_pkg::TSH_W)'(r_tsh_3);
    assign s4_p2 = (2*bptc_pkg::DIFF2_W)'(r_diff2_3) * (2*bptc_pkg::DIFF2_W)'(r_diff2_3);

    // ------------------------------------------------------------------
    // Stage 5: 5x, 7x, 11x square terms and final TEMP
    // ------------------------------------------------------------------
    logic [bptc_pkg::FIVE_W-1:0]        n_five;
    logic [bptc_pkg::SEVEN_W-1:0]       n_seven;
    logic [bptc_pkg::ELEVEN_W-1:0]      n_eleven;
    logic signed [bptc_pkg::TEMP_W-1:0] n_temp;
    logic [bptc_pkg::FIVE_W-1:0]        r_five_5;
    logic [bptc_pkg::SEVEN_W-1:0]       r_seven_5;
    logic [bptc_pkg::ELEVEN_W-1:0]      r_eleven_5;
    logic signed [bptc_pkg::TEMP_W-1:0] r_temp_5;
    logic signed [bptc_pkg::OFF1_W-1:0] r_off1_5;
    logic signed [bptc_pkg::SENS1_W-1:0] r_sens1_5;
    logic                               r_ok_5;
    logic [bptc_pkg::RAW_W-1:0]         r_d1_5;

    // second order applies below 20.00 C, the extra terms below -15.00 C
    assign n_five   = r_lo1_4 ? ({r_sq1_4, 2'b00} + {2'b00, r_sq1_4}) : '0;
    assign n_seven  = r_lo2_4 ? ({r_sq2_4, 3'b000} - {3'b000, r_sq2_4}) : '0;
    assign n_eleven = r_lo2_4 ? ({1'b0, r_sq2_4, 3'b000} + {3'b000, r_sq2_4, 1'b0}
                                + {4'b0000, r_sq2_4}) : '0;
    assign n_temp   = r_lo1_4 ? (r_temp1_4 - $signed({3'b000, r_t2_4})) : r_temp1_4;

    // ------------------------------------------------------------------
    // Stage 6: final OFF and SENS
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::OFF_W-1:0]  n_off, n_sens;
    logic signed [bptc_pkg::OFF_W-1:0]  r_off_6, r_sens_6;
    logic signed [bptc_pkg::TEMP_W-1:0] r_temp_6;
    logic                               r_ok_6;
    logic [bptc_pkg::RAW_W-1:0]         r_d1_6;

    assign n_off  = bptc_pkg::OFF_W'(r_off1_5)
                    - $signed({5'b00000, r_five_5[bptc_pkg::FIVE_W-1:1]})
                    - $signed({2'b00, r_seven_5});
    assign n_sens = bptc_pkg::OFF_W'(r_sens1_5)
                    - $signed({6'b000000, r_five_5[bptc_pkg::FIVE_W-1:2]})
                    - $signed({2'b00, r_eleven_5[bptc_pkg::ELEVEN_W-1:1]});

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS as two partial products
    // ------------------------------------------------------------------
    logic [bptc_pkg::PRD_W-1:0]         n_plo;
    logic signed [bptc_pkg::PRD_W-1:0]  n_phi;
    logic [bptc_pkg::PRD_W-1:0]         r_plo_7;
    logic signed [bptc_pkg::PRD_W-1:0]  r_phi_7;
    logic signed [bptc_pkg::OFF_W-1:0]  r_off_7;
    logic signed [bptc_pkg::TEMP_W-1:0] r_temp_7;
    logic                               r_ok_7;

    assign n_plo = bptc_pkg::PRD_W'(r_d1_6) *
                   bptc_pkg::PRD_W'(r_sens_6[bptc_pkg::SLO_W-1:0]);
    assign n_phi = bptc_pkg::PRD_W'($signed({1'b0, r_d1_6})) *
                   bptc_pkg::PRD_W'($signed(r_sens_6[bptc_pkg::OFF_W-1:bptc_pkg::SLO_W]));

    // ------------------------------------------------------------------
    // Stage 8: (D1 * SENS) >>> 21 = high product + low product >> 21
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::PRD_W-1:0]  n_q;
    logic signed [bptc_pkg::PRD_W-1:0]  r_q_8;
    logic signed [bptc_pkg::OFF_W-1:0]  r_off_8;
    logic signed [bptc_pkg::TEMP_W-1:0] r_temp_8;
    logic                               r_ok_8;

    assign n_q = r_phi_7 + $signed({21'd0, r_plo_7[bptc_pkg::PRD_W-1:bptc_pkg::SLO_W]});

    // ------------------------------------------------------------------
    // Stage 9: P = (q - OFF) >>> 15, output register
    // Both results are bounded well inside int32 for any raw value and
    // coefficient, so the flag follows the raw range check alone.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::RES_W-1:0]  s9_r;
    logic [bptc_pkg::OUT_W-1:0]         n_press, n_temp32;
    logic [2*bptc_pkg::OUT_W-1:0]       r_m_tdata;
    logic                               r_m_tuser;

    assign s9_r     = bptc_pkg::RES_W'(r_q_8) - bptc_pkg::RES_W'(r_off_8);
    assign n_press  = {s9_r[bptc_pkg::RES_W-1], s9_r[bptc_pkg::RES_W-1:15]};
    assign n_temp32 = {{(bptc_pkg::OUT_W-bptc_pkg::TEMP_W){r_temp_8[bptc_pkg::TEMP_W-1]}},
                       r_temp_8};

    assign o_m_tdata = r_m_tdata;
    assign o_m_tuser = r_m_tuser;

    // ------------------------------------------------------------------
    // Stage payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_en[0]) begin
            r_ok_1 <= n_ok;
            r_d1_1 <= s_d1;
            r_dt_1 <= n_dt;
        end
        if (s_en[1]) begin
            r_pt_2 <= n_pt;
            r_po_2 <= n_po;
            r_ps_2 <= n_ps;
            r_dd_2 <= n_dd;
            r_ok_2 <= r_ok_1;
            r_d1_2 <= r_d1_1;
        end
        if (s_en[2]) begin
            r_tsh_3   <= s3_tsh;
            r_diff2_3 <= n_diff2;
            r_temp1_3 <= n_temp1;
            r_t2_3    <= r_dd_2[31 +: bptc_pkg::T2_W];
            r_off1_3  <= n_off1;
            r_sens1_3 <= n_sens1;
            r_lo1_3   <= s3_tsh[bptc_pkg::TSH_W-1];
            r_lo2_3   <= n_diff2[bptc_pkg::DIFF2_W-1];
            r_ok_3    <= r_ok_2;
            r_d1_3    <= r_d1_2;
        end
        if (s_en[3]) begin
            r_sq1_4   <= s4_p1[bptc_pkg::SQ1_W-1:0];
            r_sq2_4   <= s4_p2[bptc_pkg::SQ2_W-1:0];
            r_temp1_4 <= r_temp1_3;
            r_t2_4    <= r_t2_3;
            r_off1_4  <= r_off1_3;
            r_sens1_4 <= r_sens1_3;
            r_lo1_4   <= r_lo1_3;
            r_lo2_4   <= r_lo2_3;
            r_ok_4    <= r_ok_3;
            r_d1_4    <= r_d1_3;
        end
        if (s_en[4]) begin
            r_five_5   <= n_five;
            r_seven_5  <= n_seven;
            r_eleven_5 <= n_eleven;
            r_temp_5   <= n_temp;
            r_off1_5   <= r_off1_4;
            r_sens1_5  <= r_sens1_4;
            r_ok_5     <= r_ok_4;
            r_d1_5     <= r_d1_4;
        end
        if (s_en[5]) begin
            r_off_6  <= n_off;
            r_sens_6 <= n_sens;
            r_temp_6 <= r_temp_5;
            r_ok_6   <= r_ok_5;
            r_d1_6   <= r_d1_5;
        end
        if (s_en[6]) begin
            r_plo_7  <= n_plo;
            r_phi_7  <= n_phi;
            r_off_7  <= r_off_6;
            r_temp_7 <= r_temp_6;
            r_ok_7   <= r_ok_6;
        end
        if (s_en[7]) begin
            r_q_8    <= n_q;
            r_off_8  <= r_off_7;
            r_temp_8 <= r_temp_7;
            r_ok_8   <= r_ok_7;
        end
        if (s_en[8]) begin
            r_m_tuser <= r_ok_8;
            r_m_tdata <= r_ok_8 ? {n_press, n_temp32} : '0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BPTC_ASSERT_IMPL(a_invalid_is_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)
    `BPTC_ASSERT_IMPL(a_stall_only_when_blocked, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)
    `BPTC_ASSERT_NEXT(a_zero_raw_flagged, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tdata[23:0] == '0 || i_s_tdata[47:24] == '0), !r_ok_1)
    `BPTC_ASSERT_NEXT(a_c6_write_lands, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && i_cfg_index == bptc_pkg::CFG_TEMP_COEFF, s_coeffs.temp_coeff == $past(i_cfg_data))

endmodule

`default_nettype wire
